// File: rtl/conv_lstm_cell_forward_core_assert.svh
// Assertion macros for the convolutional LSTM cell RTL.
// Depends on nothing; included by clc_ctrl, which checks its own logic.
`ifndef CONV_LSTM_CELL_FORWARD_CORE_ASSERT_SVH
`define CONV_LSTM_CELL_FORWARD_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define CLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/clc_pkg.sv
// Package for the convolutional LSTM cell: payload types, state codes and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package clc_pkg;
  typedef struct packed {
    logic              operation;
    logic [1:0]        gate_select;
    logic [5:0]        channel;
    logic [4:0]        tap;
    logic signed [15:0] sample_value;
    logic signed [15:0] prev_cell;
    logic              last_tap;
  } req_t;

  typedef struct packed {
    logic signed [15:0] hidden_out;
    logic signed [15:0] cell_out;
    logic [5:0]         channel_out;
  } rsp_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Gate table codes for weight writes.
  localparam logic [1:0] GATE_CAND = 2'd0;
  localparam logic [1:0] GATE_IN   = 2'd1;
  localparam logic [1:0] GATE_FORG = 2'd2;
  localparam logic [1:0] GATE_OUT  = 2'd3;

  // Datapath commands from the controller.
  typedef struct packed {
    logic        mem_wr;     // write weight
    logic        mem_rd;     // read four weights of a tap
    logic        mac;        // accumulate registered weights
    logic        fin_start;  // start gate evaluation
    logic        clear;      // clear gate sums
  } cmd_t;

  typedef struct packed {
    logic fin_done;
  } sts_t;

  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] EXP_SEED = 32'd1073217664;
  localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;

  // Finish-sequencer state codes.
  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_PRE  = 3'd1;
  localparam logic [2:0] F_EXP  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_CELL = 3'd4;
  localparam logic [2:0] F_HID  = 3'd5;
  localparam logic [2:0] F_DONE = 3'd6;
endpackage

// File: rtl/conv_lstm_cell_forward_core.sv
// Top level of the convolutional LSTM cell forward core.
// Depends on clc_pkg, clc_ctrl and clc_datapath.
// Usage: one input channel (in_valid_i/in_ready_o, payload in_req_i) takes weight
// writes and tap samples. Weight writes and non-final samples may follow back to
// back. A sample with last_tap set finishes the element and yields one result on
// the output channel (out_valid_o/out_ready_i, payload out_rsp_o).
// A finishing sample: out_valid_o rises after a start step, five passes through the shared
// activation unit (start, exponent steps, divide steps, done) and the cell, hidden and
// hand-off steps. Input is held off from the accepting edge until the result is taken;
// the next request can be accepted at the edge after that.
// Reset clears control state and the gate sums; the weight memory holds garbage
// until written. When the receiver stalls the result holds and no new request is
// accepted until it is taken.
`timescale 1ns / 1ps
module conv_lstm_cell_forward_core #(
  parameter int Channels = 64,
  parameter int Taps     = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  clc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output clc_pkg::rsp_t out_rsp_o
);
  clc_pkg::cmd_t cmd;
  clc_pkg::sts_t sts;

  clc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_i(in_req_i),
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  clc_datapath #(.Channels(Channels), .Taps(Taps)) u_dp (
    .clk_i, .rst_ni, .req_i(in_req_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_rsp_o)
  );
endmodule

// File: rtl/clc_act.sv
// Sequential activation unit: sigmoid or tanh of a Q4.11 value, bit by bit.
// Depends on clc_pkg for the exponent constants.
`timescale 1ns / 1ps
module clc_act (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               is_tanh_i,
  input  logic signed [15:0] x_i,
  output logic               done_o,
  output logic signed [15:0] y_o
);
  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_EXP  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;

  logic [1:0]  st_q, st_d;
  logic [16:0] t_q;
  logic [4:0]  j_q;
  logic [31:0] acc_q, c_q;
  logic        neg_q, tanh_q;
  logic [42:0] num_q, rem_q;
  logic [31:0] den_q;
  logic [12:0] quo_q;
  logic [5:0]  k_q;
  logic        done_q;
  logic [63:0] prod, sq;
  logic [16:0] mag;
  logic [43:0] trial;
  logic [31:0] e_fin, den_fin;

  assign mag     = x_i[15] ? 17'(-$signed({x_i[15], x_i})) : 17'({1'b0, x_i});
  assign prod    = 64'(acc_q) * 64'(c_q) + 64'd536870912;
  assign sq      = 64'(c_q) * 64'(c_q) + 64'd536870912;
  assign e_fin   = t_q[j_q] ? prod[61:30] : acc_q;
  assign den_fin = clc_pkg::ONE_Q30 + e_fin;
  assign trial   = {rem_q, num_q[42]};

  // Exponent by set bits, then restoring division one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      A_IDLE: if (start_i) st_d = A_EXP;
      A_EXP:  if (j_q == 5'd16) st_d = A_DIV;
      A_DIV:  if (k_q == 6'd42) st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  // The exponent factor is squared with rounding on every step.
  always_ff @(posedge clk_i) begin
    case (st_q)
      A_IDLE: begin
        t_q    <= is_tanh_i ? {mag[15:0], 1'b0} : mag;
        neg_q  <= x_i[15];
        tanh_q <= is_tanh_i;
        j_q    <= '0;
        acc_q  <= clc_pkg::ONE_Q30;
        c_q    <= clc_pkg::EXP_SEED;
      end
      A_EXP: begin
        if (t_q[j_q]) acc_q <= prod[61:30];
        c_q <= sq[61:30];
        if (j_q == 5'd16) begin
          den_q <= den_fin;
          num_q <= tanh_q
            ? (43'(clc_pkg::ONE_Q30 - e_fin) << 11) + 43'(den_fin >> 1)
            : (43'd1 << 41) + 43'(den_fin >> 1);
          rem_q <= '0;
          quo_q <= '0;
          k_q   <= '0;
        end else begin
          j_q <= j_q + 5'd1;
        end
      end
      A_DIV: begin
        if (trial >= 44'(den_q)) begin
          rem_q <= 43'(trial - 44'(den_q));
          quo_q <= {quo_q[11:0], 1'b1};
        end else begin
          rem_q <= trial[42:0];
          quo_q <= {quo_q[11:0], 1'b0};
        end
        num_q <= {num_q[41:0], 1'b0};
        k_q   <= k_q + 6'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (st_q == A_DIV) && (k_q == 6'd42);
  end
  assign done_o = done_q;
  always_comb begin
    if (tanh_q) y_o = neg_q ? -$signed({3'b0, quo_q}) : $signed({3'b0, quo_q});
    else y_o = neg_q ? 16'sd2048 - $signed({3'b0, quo_q}) : $signed({3'b0, quo_q});
  end
endmodule

// File: rtl/clc_datapath.sv
// Datapath: weight memory, four gate accumulators, activation unit and cell math.
// Depends on clc_pkg and clc_act.
`timescale 1ns / 1ps
module clc_datapath #(
  parameter int Channels = 64,
  parameter int Taps     = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  clc_pkg::req_t req_i,
  input  clc_pkg::cmd_t cmd_i,
  output clc_pkg::sts_t sts_o,
  output clc_pkg::rsp_t rsp_o
);
  localparam int Depth = Taps * Channels;
  localparam int AW    = $clog2(Depth);

  logic [15:0] mem0 [Depth];
  logic [15:0] mem1 [Depth];
  logic [15:0] mem2 [Depth];
  logic [15:0] mem3 [Depth];
  logic signed [15:0] w_q [4];
  logic signed [15:0] val_q, prev_q;
  logic               rng_q;
  logic signed [39:0] sum_q [4];
  logic [AW-1:0] addr;
  logic in_rng;
  clc_pkg::rsp_t rsp_q;

  assign in_rng = (32'(req_i.tap) < Taps) && (32'(req_i.channel) < Channels);
  assign addr   = AW'(32'(req_i.tap) * Channels + 32'(req_i.channel));

  // Weight memory: four banks, one per gate, written one entry, read per tap.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && in_rng) begin
      case (req_i.gate_select)
        clc_pkg::GATE_CAND: mem0[addr] <= req_i.sample_value;
        clc_pkg::GATE_IN:   mem1[addr] <= req_i.sample_value;
        clc_pkg::GATE_FORG: mem2[addr] <= req_i.sample_value;
        default: mem3[addr] <= req_i.sample_value;
      endcase
    end
    if (cmd_i.mem_rd) begin
      if (in_rng) begin
        w_q[0] <= mem0[addr]; w_q[1] <= mem1[addr];
        w_q[2] <= mem2[addr]; w_q[3] <= mem3[addr];
      end
      val_q  <= req_i.sample_value;
      prev_q <= req_i.prev_cell;
      rng_q  <= in_rng;
    end
  end

  // Gate accumulators with saturation.
  for (genvar g = 0; g < 4; g++) begin : g_acc
    logic signed [31:0] p;
    logic signed [41:0] s;
    assign p = w_q[g] * val_q;
    assign s = 42'(sum_q[g]) + 42'(p);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sum_q[g] <= '0;
      else if (cmd_i.clear) sum_q[g] <= '0;
      else if (cmd_i.mac && rng_q) begin
        if (s > 42'(clc_pkg::SUM_MAX)) sum_q[g] <= clc_pkg::SUM_MAX;
        else if (s < 42'(clc_pkg::SUM_MIN)) sum_q[g] <= clc_pkg::SUM_MIN;
        else sum_q[g] <= s[39:0];
      end
    end
  end

  function automatic logic signed [15:0] rsat(input logic signed [40:0] v);
    logic signed [40:0] r;
    r = (v + 41'sd1024) >>> 11;
    if (r > 41'sd32767) return 16'sh7fff;
    if (r < -41'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // Finish sequencer: five activations on the shared unit; cell math comes before the fifth, hidden after it.
  logic [2:0] fst_q;
  logic [2:0] idx_q;
  logic signed [15:0] gv_q [4];
  logic       a_start, a_done;
  logic signed [15:0] a_x, a_y;
  logic signed [31:0] p1_q, p2_q;
  logic signed [15:0] cell_q;

  assign a_x = (idx_q == 3'd4) ? cell_q : rsat(41'(sum_q[idx_q[1:0]]));

  clc_act u_act (
    .clk_i, .rst_ni, .start_i(a_start), .is_tanh_i(idx_q inside {3'd0, 3'd4}),
    .x_i(a_x), .done_o(a_done), .y_o(a_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q <= clc_pkg::F_IDLE;
      idx_q <= '0;
    end else begin
      case (fst_q)
        clc_pkg::F_IDLE: if (cmd_i.fin_start) begin
          fst_q <= clc_pkg::F_PRE; idx_q <= '0;
        end
        clc_pkg::F_PRE: fst_q <= clc_pkg::F_EXP;
        clc_pkg::F_EXP: if (a_done) begin
          if (idx_q == 3'd3) fst_q <= clc_pkg::F_CELL;
          else if (idx_q == 3'd4) fst_q <= clc_pkg::F_HID;
          else begin idx_q <= idx_q + 3'd1; fst_q <= clc_pkg::F_PRE; end
        end
        clc_pkg::F_CELL: fst_q <= clc_pkg::F_DIV;
        clc_pkg::F_DIV: begin idx_q <= 3'd4; fst_q <= clc_pkg::F_PRE; end
        clc_pkg::F_HID: fst_q <= clc_pkg::F_DONE;
        clc_pkg::F_DONE: fst_q <= clc_pkg::F_IDLE;
        default: fst_q <= clc_pkg::F_IDLE;
      endcase
    end
  end

  assign a_start = (fst_q == clc_pkg::F_PRE);

  // Gate values, cell and hidden math; the channel follows each sample read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rsp_q.channel_out <= req_i.channel;
    if (fst_q == clc_pkg::F_EXP && a_done && idx_q != 3'd4) gv_q[idx_q[1:0]] <= a_y;
    if (fst_q == clc_pkg::F_CELL) begin
      p1_q <= prev_q * gv_q[2];
      p2_q <= gv_q[1] * gv_q[0];
    end
    if (fst_q == clc_pkg::F_DIV) begin
      cell_q <= rsat(41'(p1_q) + 41'(p2_q));
      rsp_q.cell_out <= rsat(41'(p1_q) + 41'(p2_q));
    end
    if (fst_q == clc_pkg::F_EXP && a_done && idx_q == 3'd4) p1_q <= a_y * gv_q[3];
    if (fst_q == clc_pkg::F_HID) rsp_q.hidden_out <= rsat(41'(p1_q));
  end

  assign rsp_o = rsp_q;
  assign sts_o.fin_done = (fst_q == clc_pkg::F_DONE);
endmodule

// File: rtl/clc_ctrl.sv
// Controller: request handshake, accumulate timing, finish and result hand-off.
// Depends on clc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "conv_lstm_cell_forward_core_assert.svh"
module clc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  clc_pkg::req_t req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output clc_pkg::cmd_t cmd_o,
  input  clc_pkg::sts_t sts_i
);
  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_FIN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] st_q, st_d;
  logic       mac_q, last_q, acc;

  assign in_ready_o  = (st_q == S_RUN) && !(mac_q && last_q);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == S_OUT);

  always_comb begin
    cmd_o.mem_wr    = acc && req_i.operation == clc_pkg::OP_WRITE;
    cmd_o.mem_rd    = acc && req_i.operation == clc_pkg::OP_SAMPLE;
    cmd_o.mac       = mac_q;
    cmd_o.fin_start = (st_q == S_RUN) && mac_q && last_q;
    cmd_o.clear     = (st_q == S_OUT) && out_ready_i;
    st_d = st_q;
    case (st_q)
      S_RUN: if (mac_q && last_q) st_d = S_FIN;
      S_FIN: if (sts_i.fin_done) st_d = S_OUT;
      S_OUT: if (out_ready_i) st_d = S_RUN;
      default: st_d = S_RUN;
    endcase
  end

  // Sample read this cycle accumulates next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_RUN; mac_q <= 1'b0; last_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mac_q  <= cmd_o.mem_rd;
      last_q <= cmd_o.mem_rd && req_i.last_tap;
    end
  end

  `CLC_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != S_RUN, !in_ready_o)
  `CLC_ASSERT_NEXT(a_fin_follows, clk_i, rst_ni, cmd_o.fin_start, st_q == S_FIN)
  `CLC_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, st_d == S_OUT)
endmodule
